[src/ufpm_pkg.sv]
// Shared types, constants and the LED grading function for the proximity monitor.
// Depends on nothing; every other file of the block but ufpm_if imports it.
package ufpm_pkg;

  localparam int LED_COUNT = 8;
  localparam int LED_W     = 3;
  localparam int SEL_W     = 2;

  localparam logic [7:0] START_BYTE         = 8'd250;
  localparam logic [7:0] FIRST_CODE         = 8'd251;
  localparam logic [7:0] NO_DISTANCE        = 8'd255;
  localparam logic [7:0] MIN_DISTANCE_RESET = 8'd50;
  localparam logic [LED_W-1:0] LAST_LED     = 3'd7;

  typedef enum logic [1:0] {
    PH_WAIT,
    PH_CODE,
    PH_DATA
  } parse_phase_t;

  typedef enum logic [1:0] {
    EV_IDLE,
    EV_SCAN,
    EV_EMIT
  } eval_state_t;

  typedef struct packed {
    logic err;
  } eval_cmd_t;

  typedef struct packed {
    logic busy;
  } eval_status_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
  } led_color_t;

  // Grades one distance into a colour; zero means no echo and counts as far.
  function automatic led_color_t grade(input logic [7:0] d);
    led_color_t c;
    priority if (d > 8'd200 || d == 8'd0) begin
      c = '{red: 8'd0, green: 8'd50};
    end else if (d > 8'd180) begin
      c = '{red: 8'd20, green: 8'd50};
    end else if (d > 8'd150) begin
      c = '{red: 8'd35, green: 8'd50};
    end else if (d > 8'd120) begin
      c = '{red: 8'd50, green: 8'd50};
    end else if (d > 8'd100) begin
      c = '{red: 8'd50, green: 8'd35};
    end else if (d > 8'd80) begin
      c = '{red: 8'd50, green: 8'd20};
    end else if (d > 8'd60) begin
      c = '{red: 8'd204, green: 8'd102};
    end else if (d > 8'd50) begin
      c = '{red: 8'd250, green: 8'd60};
    end else begin
      c = '{red: 8'd50, green: 8'd0};
    end
    return c;
  endfunction

endpackage

[src/ufpm_if.sv]
// Valid/ready channel interfaces for received bytes and LED results.
// Depends on nothing; used by the top level, the front end and the evaluator.
interface ufpm_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface ufpm_led_if;
  logic       valid;
  logic       ready;
  logic [2:0] led_index;
  logic [7:0] red;
  logic [7:0] green;
  logic       stop_request;
  logic       frame_error;
  logic       last;

  modport source (output valid, output led_index, output red, output green,
                  output stop_request, output frame_error, output last, input ready);
  modport sink   (input valid, input led_index, input red, input green,
                  input stop_request, input frame_error, input last, output ready);
endinterface

[src/ultrasonic_frame_proximity_monitor_top.sv]
// Top level of the ultrasonic frame proximity monitor.
// Depends on ufpm_pkg, ufpm_if, ufpm_cmd_fifo, ufpm_front and ufpm_back.
//
//   Channel    Direction  Payload                                      Handshake
//   byte_in    in         rx_byte[7:0]                                 valid/ready
//   led_out    out        led_index, red, green, stop_request,         valid/ready
//                         frame_error, last
//   cfg        in         cfg_wdata[7:0] (min_distance)                cfg_we, no wait
//
// A byte that completes a frame, or a bad sensor code, queues an evaluation. The
// evaluator scans the store one entry per cycle through the single store read
// port, then emits eight LED requests, one per cycle while led_out is ready.
// Reset is synchronous and clears the parser, the queue and the whole store.
// Distance bytes stall on byte_in while an evaluation is queued or running, so
// the store is never overwritten under a scan; start and ignored bytes always flow,
// and sensor code bytes flow unless two evaluations are already waiting in the queue.
module ultrasonic_frame_proximity_monitor_top
  import ufpm_pkg::*;
#(
  parameter int FRAME_BYTES  = 8,
  parameter int SENSOR_COUNT = 3
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata,
  ufpm_byte_if.sink  byte_in,
  ufpm_led_if.source led_out
);

  localparam int DEPTH = SENSOR_COUNT * FRAME_BYTES;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // Stop threshold register.
  logic [7:0] min_distance;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_distance <= MIN_DISTANCE_RESET;
    end else if (cfg_we) begin
      min_distance <= cfg_wdata;
    end
  end

  eval_cmd_t     push_cmd;
  eval_cmd_t     pop_cmd;
  logic          cmd_push;
  logic          cmd_pop;
  logic          cmd_empty;
  logic          cmd_full;
  logic          store_we;
  eval_status_t  back_status;
  logic [AW-1:0] rd_addr;
  logic [7:0]    rd_data;

  // The front end parses frames and owns the distance store.
  ufpm_front #(
    .FRAME_BYTES  (FRAME_BYTES),
    .SENSOR_COUNT (SENSOR_COUNT)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .byte_in   (byte_in),
    .status    (back_status),
    .cmd_empty (cmd_empty),
    .cmd_full  (cmd_full),
    .cmd_push  (cmd_push),
    .cmd       (push_cmd),
    .store_we  (store_we),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data)
  );

  // Pending evaluations; each carries only the frame error flag.
  ufpm_cmd_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (cmd_push),
    .push_data (push_cmd),
    .pop       (cmd_pop),
    .pop_data  (pop_cmd),
    .empty     (cmd_empty),
    .full      (cmd_full)
  );

  // The back end finds the minima and sends the LED requests.
  ufpm_back #(
    .FRAME_BYTES  (FRAME_BYTES),
    .SENSOR_COUNT (SENSOR_COUNT)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .min_distance (min_distance),
    .cmd_valid    (!cmd_empty),
    .cmd          (pop_cmd),
    .cmd_pop      (cmd_pop),
    .rd_addr      (rd_addr),
    .rd_data      (rd_data),
    .status       (back_status),
    .led_out      (led_out)
  );

  // The store must stay frozen while an evaluation reads it.
  assert property (@(posedge clk) disable iff (rst)
    !(store_we && (back_status.busy || !cmd_empty)))
    else $error("distance store written during an evaluation");

  // The parser never queues an evaluation into a full queue.
  assert property (@(posedge clk) disable iff (rst) !(cmd_push && cmd_full))
    else $error("evaluation command pushed into a full queue");

  // An evaluation only starts from a queued command.
  assert property (@(posedge clk) disable iff (rst)
    $rose(back_status.busy) |-> $past(cmd_pop))
    else $error("evaluator started without a queued command");

  // The closing request of an evaluation is always the last LED.
  assert property (@(posedge clk) disable iff (rst)
    (led_out.valid && led_out.last) |-> (led_out.led_index == LAST_LED))
    else $error("last flag on a request that is not the last LED");

endmodule

[src/ufpm_cmd_fifo.sv]
// Two-entry queue of evaluation commands between the parser and the evaluator.
// Depends on ufpm_pkg for the command type.
module ufpm_cmd_fifo
  import ufpm_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  eval_cmd_t push_data,
  input  logic      pop,
  output eval_cmd_t pop_data,
  output logic      empty,
  output logic      full
);

  eval_cmd_t  slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign empty    = (count == 2'd0);
  assign full     = (count == 2'd2);
  assign pop_data = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push && !full) begin
        slot[wr_ptr] <= push_data;
        wr_ptr       <= ~wr_ptr;
      end
      if (pop && !empty) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, (push && !full)} - {1'b0, (pop && !empty)};
    end
  end

endmodule

[src/ufpm_front.sv]
// Frame parser and distance store: accepts bytes, fills the store, queues evaluations.
// Depends on ufpm_pkg and the ufpm_byte_if interface.
module ufpm_front
  import ufpm_pkg::*;
#(
  parameter int FRAME_BYTES  = 8,
  parameter int SENSOR_COUNT = 3,
  localparam int DEPTH = SENSOR_COUNT * FRAME_BYTES,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             rst,
  ufpm_byte_if.sink        byte_in,
  input  eval_status_t     status,
  input  logic             cmd_empty,
  input  logic             cmd_full,
  output logic             cmd_push,
  output eval_cmd_t        cmd,
  output logic             store_we,
  input  logic [AW-1:0]    rd_addr,
  output logic [7:0]       rd_data
);

  localparam int CNT_W = (FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1;

  parse_phase_t     phase, phase_next;
  logic [SEL_W-1:0] sensor_select, sensor_select_next;
  logic [CNT_W-1:0] byte_count, byte_count_next;
  logic [7:0]       store [DEPTH];

  logic             accept;
  logic             code_ok;
  logic             frame_end;
  logic [AW-1:0]    wr_addr;

  assign accept    = byte_in.valid && byte_in.ready;
  assign code_ok   = ({1'b0, byte_in.rx_byte} >= {1'b0, FIRST_CODE}) &&
                     ({1'b0, byte_in.rx_byte} < ({1'b0, FIRST_CODE} + 9'(SENSOR_COUNT)));
  assign frame_end = (byte_count == CNT_W'(FRAME_BYTES - 1));
  assign wr_addr   = AW'(AW'(sensor_select) * AW'(FRAME_BYTES) + AW'(byte_count));
  assign rd_data   = (int'(rd_addr) < DEPTH) ? store[rd_addr] : 8'd0;

  // Next state of the parser.
  always_comb begin
    phase_next         = phase;
    sensor_select_next = sensor_select;
    byte_count_next    = byte_count;
    if (accept) begin
      unique case (phase)
        PH_WAIT: begin
          phase_next = (byte_in.rx_byte == START_BYTE) ? PH_CODE : PH_WAIT;
        end
        PH_CODE: begin
          if (code_ok) begin
            phase_next         = PH_DATA;
            sensor_select_next = SEL_W'(byte_in.rx_byte - FIRST_CODE);
            byte_count_next    = '0;
          end else begin
            phase_next = PH_WAIT;
          end
        end
        PH_DATA: begin
          if (frame_end) begin
            phase_next      = PH_WAIT;
            byte_count_next = '0;
          end else begin
            byte_count_next = byte_count + 1'b1;
          end
        end
        default: phase_next = PH_WAIT;
      endcase
    end
  end

  // Handshake, store write and command push. The store may only change while
  // no evaluation is queued or running.
  always_comb begin
    byte_in.ready = 1'b1;
    store_we      = 1'b0;
    cmd_push      = 1'b0;
    cmd.err       = 1'b0;
    unique case (phase)
      PH_WAIT: byte_in.ready = 1'b1;
      PH_CODE: begin
        byte_in.ready = !cmd_full;
        cmd_push      = accept && !code_ok;
        cmd.err       = 1'b1;
      end
      PH_DATA: begin
        byte_in.ready = cmd_empty && !status.busy;
        store_we      = accept;
        cmd_push      = accept && frame_end;
      end
      default: byte_in.ready = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_WAIT;
      sensor_select <= '0;
      byte_count    <= '0;
      for (int i = 0; i < DEPTH; i++) begin
        store[i] <= 8'd0;
      end
    end else begin
      phase         <= phase_next;
      sensor_select <= sensor_select_next;
      byte_count    <= byte_count_next;
      if (store_we) begin
        store[wr_addr] <= byte_in.rx_byte;
      end
    end
  end

endmodule

[src/ufpm_back.sv]
// Evaluator: scans the distance store for minima and emits the eight LED results.
// Depends on ufpm_pkg and the ufpm_led_if interface.
module ufpm_back
  import ufpm_pkg::*;
#(
  parameter int FRAME_BYTES  = 8,
  parameter int SENSOR_COUNT = 3,
  localparam int DEPTH = SENSOR_COUNT * FRAME_BYTES,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic [7:0]    min_distance,
  input  logic          cmd_valid,
  input  eval_cmd_t     cmd,
  output logic          cmd_pop,
  output logic [AW-1:0] rd_addr,
  input  logic [7:0]    rd_data,
  output eval_status_t  status,
  ufpm_led_if.source    led_out
);

  localparam int CNT_W = (FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1;

  eval_state_t      state, state_next;
  logic [AW-1:0]    addr;
  logic [CNT_W-1:0] k;
  logic [SEL_W-1:0] s;
  logic [7:0]       cur_min;
  logic [7:0]       m0;
  logic             stop_acc;
  logic             err;
  logic [LED_W-1:0] led;

  logic             out_valid;
  logic [LED_W-1:0] out_index;
  led_color_t       out_color;
  logic             out_stop;
  logic             out_err;
  logic             out_last;

  logic             load;
  logic [7:0]       new_min;
  logic             sensor_end;
  logic             last_sensor;
  logic             match;
  logic [7:0]       m0_eff;
  logic [7:0]       led_dist;

  assign new_min     = (rd_data != 8'd0 && rd_data < cur_min) ? rd_data : cur_min;
  assign sensor_end  = (k == CNT_W'(FRAME_BYTES - 1));
  assign last_sensor = (s == SEL_W'(SENSOR_COUNT - 1));
  assign m0_eff      = (s == '0) ? new_min : m0;
  assign match       = (s == '0) || (new_min == m0);
  assign led_dist    = (int'(led) < FRAME_BYTES) ? rd_data : 8'd0;

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      EV_IDLE: if (cmd_valid) state_next = EV_SCAN;
      EV_SCAN: if (sensor_end && last_sensor) state_next = EV_EMIT;
      EV_EMIT: if (load && led == LAST_LED) state_next = EV_IDLE;
      default: state_next = EV_IDLE;
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    cmd_pop     = 1'b0;
    rd_addr     = addr;
    load        = 1'b0;
    status.busy = (state != EV_IDLE);
    unique case (state)
      EV_IDLE: cmd_pop = cmd_valid;
      EV_SCAN: rd_addr = addr;
      EV_EMIT: begin
        rd_addr = AW'(led);
        load    = !out_valid || led_out.ready;
      end
      default: cmd_pop = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= EV_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (led_out.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      EV_IDLE: begin
        if (cmd_valid) begin
          err      <= cmd.err;
          addr     <= '0;
          k        <= '0;
          s        <= '0;
          cur_min  <= NO_DISTANCE;
          stop_acc <= 1'b1;
        end
      end
      EV_SCAN: begin
        addr <= AW'(addr + 1'b1);
        if (sensor_end) begin
          k       <= '0;
          s       <= SEL_W'(s + 1'b1);
          cur_min <= NO_DISTANCE;
          led     <= '0;
          if (s == '0) begin
            m0 <= new_min;
          end
          if (last_sensor) begin
            stop_acc <= stop_acc && match && (m0_eff < min_distance);
          end else begin
            stop_acc <= stop_acc && match;
          end
        end else begin
          k       <= k + 1'b1;
          cur_min <= new_min;
        end
      end
      EV_EMIT: begin
        if (load) begin
          led       <= led + 1'b1;
          out_index <= led;
          out_color <= grade(led_dist);
          out_stop  <= stop_acc;
          out_err   <= err;
          out_last  <= (led == LAST_LED);
        end
      end
      default: ;
    endcase
  end

  assign led_out.valid        = out_valid;
  assign led_out.led_index    = out_index;
  assign led_out.red          = out_color.red;
  assign led_out.green        = out_color.green;
  assign led_out.stop_request = out_stop;
  assign led_out.frame_error  = out_err;
  assign led_out.last         = out_last;

endmodule

[test/tb_ultrasonic_frame_proximity_monitor_top.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the ultrasonic frame proximity monitor top level.
// Depends on ufpm_pkg, ufpm_if and the RTL under src; it predicts every LED request itself.
module tb_ultrasonic_frame_proximity_monitor_top
  import ufpm_pkg::*;
;

  localparam int FRAME_BYTES  = 8;
  localparam int SENSOR_COUNT = 3;

  // One evaluation scans the whole store and then emits eight LED requests.
  localparam int SETTLE_CYCLES = 2 * (SENSOR_COUNT * FRAME_BYTES + 9);
  localparam int PHASE_ITEMS   = 60;
  localparam int PHASE_COUNT   = 6;
  localparam int HOLD_CYCLES   = 500;
  localparam int TIMEOUT_NS    = 5_000_000;

  // Distances that sit on both sides of every grading step.
  localparam logic [7:0] GRADE_BOUNDS [18] = '{
    8'd0, 8'd1, 8'd50, 8'd51, 8'd60, 8'd61, 8'd80, 8'd81, 8'd100,
    8'd101, 8'd120, 8'd121, 8'd150, 8'd151, 8'd180, 8'd181, 8'd200, 8'd201
  };

  // The directed sensor 0 frame: no echo, the top value, a data byte equal to
  // the start byte, and values around the outer and inner grading steps.
  localparam logic [7:0] DIRECTED_ECHO [FRAME_BYTES] = '{
    8'd0, 8'd255, 8'd250, 8'd201, 8'd200, 8'd181, 8'd51, 8'd50
  };

  typedef enum int {
    FILL_ALIGNED,
    FILL_BOUNDARY,
    FILL_RANDOM,
    FILL_ZERO
  } frame_fill_t;

  typedef struct packed {
    logic [2:0] led_index;
    logic [7:0] red;
    logic [7:0] green;
    logic       stop_request;
    logic       frame_error;
    logic       last;
  } led_result_t;

  // The scoreboard keeps its own copy of the parser, the distance store and
  // the threshold. Every accepted byte goes through note_byte, and each
  // evaluation it triggers queues the eight LED requests the block must send.
  class proximity_scoreboard;
    logic [7:0]   threshold;
    parse_phase_t phase;
    int           sensor;
    int           filled;
    logic [7:0]   echo [SENSOR_COUNT * FRAME_BYTES];
    led_result_t  pending [$];
    int           errors;

    function new();
      threshold = MIN_DISTANCE_RESET;
      phase     = PH_WAIT;
      sensor    = 0;
      filled    = 0;
      errors    = 0;
      foreach (echo[k]) echo[k] = 8'd0;
    endfunction

    function logic [7:0] nearest_echo(int s);
      logic [7:0] best;
      best = NO_DISTANCE;
      for (int k = 0; k < FRAME_BYTES; k++) begin
        if (echo[s * FRAME_BYTES + k] != 8'd0 && echo[s * FRAME_BYTES + k] < best) begin
          best = echo[s * FRAME_BYTES + k];
        end
      end
      return best;
    endfunction

    function void grade_led(logic [7:0] d, output logic [7:0] r, output logic [7:0] g);
      if (d == 8'd0 || d > 8'd200) begin
        r = 8'd0;   g = 8'd50;
      end else if (d > 8'd180) begin
        r = 8'd20;  g = 8'd50;
      end else if (d > 8'd150) begin
        r = 8'd35;  g = 8'd50;
      end else if (d > 8'd120) begin
        r = 8'd50;  g = 8'd50;
      end else if (d > 8'd100) begin
        r = 8'd50;  g = 8'd35;
      end else if (d > 8'd80) begin
        r = 8'd50;  g = 8'd20;
      end else if (d > 8'd60) begin
        r = 8'd204; g = 8'd102;
      end else if (d > 8'd50) begin
        r = 8'd250; g = 8'd60;
      end else begin
        r = 8'd50;  g = 8'd0;
      end
    endfunction

    function void evaluate_leds(logic err);
      logic [7:0]  m0;
      logic        stop;
      logic [7:0]  d;
      led_result_t res;
      m0   = nearest_echo(0);
      stop = (m0 < threshold);
      for (int s = 1; s < SENSOR_COUNT; s++) begin
        if (nearest_echo(s) != m0) stop = 1'b0;
      end
      for (int i = 0; i < LED_COUNT; i++) begin
        d = (i < FRAME_BYTES) ? echo[i] : 8'd0;
        res.led_index    = i[2:0];
        grade_led(d, res.red, res.green);
        res.stop_request = stop;
        res.frame_error  = err;
        res.last         = (i == LED_COUNT - 1);
        pending.push_back(res);
      end
    endfunction

    function void note_byte(logic [7:0] b);
      case (phase)
        PH_CODE: begin
          if (b >= FIRST_CODE && b < FIRST_CODE + SENSOR_COUNT) begin
            sensor = int'(b - FIRST_CODE);
            filled = 0;
            phase  = PH_DATA;
          end else begin
            phase = PH_WAIT;
            evaluate_leds(1'b1);
          end
        end
        PH_DATA: begin
          echo[sensor * FRAME_BYTES + filled] = b;
          filled++;
          if (filled >= FRAME_BYTES) begin
            filled = 0;
            phase  = PH_WAIT;
            evaluate_leds(1'b0);
          end
        end
        default: begin
          phase = (b == START_BYTE) ? PH_CODE : PH_WAIT;
        end
      endcase
    endfunction

    function void compare(string field, logic [7:0] want, logic [7:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t: LED request %s mismatch, expected %0d, actual %0d",
                 $time, field, want, got);
      end
    endfunction

    function void check_led(led_result_t got);
      led_result_t want;
      if (pending.size() == 0) begin
        errors++;
        $display("%0t: LED request with nothing expected, expected none, actual led_index %0d",
                 $time, got.led_index);
      end else begin
        want = pending.pop_front();
        compare("led_index", 8'(want.led_index), 8'(got.led_index));
        compare("red", want.red, got.red);
        compare("green", want.green, got.green);
        compare("stop_request", 8'(want.stop_request), 8'(got.stop_request));
        compare("frame_error", 8'(want.frame_error), 8'(got.frame_error));
        compare("last", 8'(want.last), 8'(got.last));
      end
    endfunction
  endclass

  logic       clk;
  logic       rst;
  logic       cfg_we;
  logic [7:0] cfg_wdata;

  ufpm_byte_if rx_ch ();
  ufpm_led_if  led_ch ();

  proximity_scoreboard sb;

  // Traffic shaping shared by the stimulus and the LED sink.
  int         pend_gap;
  bit         no_idle;
  logic       hold_start;
  logic       hold_off;
  int         offered_items;
  logic [7:0] shared_min;

  ultrasonic_frame_proximity_monitor_top #(
    .FRAME_BYTES (FRAME_BYTES),
    .SENSOR_COUNT(SENSOR_COUNT)
  ) DUT (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .byte_in  (rx_ch),
    .led_out  (led_ch)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Offers one byte and returns right after the edge that accepted it. The
  // idle gap before the next byte is drawn here, so that valid is lowered in
  // the accepting step only when a gap follows; back-to-back bytes keep it high.
  task automatic send_byte(input logic [7:0] b, input bit counted);
    if (pend_gap > 0) begin
      repeat (pend_gap) @(posedge clk);
    end
    rx_ch.valid   <= 1'b1;
    rx_ch.rx_byte <= b;
    @(posedge clk);
    while (!rx_ch.ready) @(posedge clk);
    sb.note_byte(b);
    if (counted) offered_items++;
    pend_gap = no_idle ? 0 : $urandom_range(0, 9);
    if (pend_gap > 0) rx_ch.valid <= 1'b0;
  endtask

  // Drops valid when the last byte left it high.
  task automatic stop_sending();
    if (pend_gap == 0) rx_ch.valid <= 1'b0;
  endtask

  // Waits for every predicted LED request, then lets the evaluator settle, since
  // a header byte accepted last may still be moving through the front end.
  task automatic wait_drained();
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_threshold(input logic [7:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.threshold = value;
  endtask

  // A start byte followed by a sensor code and eight distances. Aligned frames
  // keep shared_min as their least nonzero distance, so that runs of them over
  // all three sensors make the minima equal and exercise the stop request.
  task automatic send_frame(input int s, input frame_fill_t fill);
    logic [7:0] d [FRAME_BYTES];
    int anchor;
    anchor = $urandom_range(0, FRAME_BYTES - 1);
    for (int k = 0; k < FRAME_BYTES; k++) begin
      case (fill)
        FILL_ALIGNED: begin
          if (k == anchor) begin
            d[k] = shared_min;
          end else if ($urandom_range(0, 3) == 0) begin
            d[k] = 8'd0;
          end else begin
            d[k] = 8'(shared_min + $urandom_range(0, 255 - shared_min));
          end
        end
        FILL_BOUNDARY: d[k] = GRADE_BOUNDS[$urandom_range(0, 17)];
        FILL_ZERO:     d[k] = 8'd0;
        default:       d[k] = 8'($urandom);
      endcase
    end
    send_byte(START_BYTE, 1'b1);
    send_byte(8'(FIRST_CODE + s), 1'b1);
    for (int k = 0; k < FRAME_BYTES; k++) send_byte(d[k], 1'b1);
  endtask

  function automatic logic [7:0] pick_min();
    if ($urandom_range(0, 1) == 1) return GRADE_BOUNDS[$urandom_range(0, 17)];
    return 8'($urandom_range(1, 255));
  endfunction

  // LED sink. After each accepted request it draws how many cycles it keeps
  // ready low; while the hold-off runs it keeps ready low regardless.
  initial begin : led_sink
    int gap;
    gap = 0;
    led_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst) begin
        gap = 0;
      end else if (led_ch.ready && led_ch.valid) begin
        gap = no_idle ? 0 : $urandom_range(0, 9);
        if (gap != 0 || hold_off) led_ch.ready <= 1'b0;
      end else if (led_ch.ready) begin
        if (hold_off) led_ch.ready <= 1'b0;
      end else if (gap != 0) begin
        gap--;
      end else if (!hold_off) begin
        led_ch.ready <= 1'b1;
      end
    end
  end

  // Long receiver stall, counted here in cycles, while the stimulus keeps
  // offering bytes. The pending evaluation backs up and the block has to hold
  // off the distance bytes of the following frame.
  initial begin : led_hold
    hold_off = 1'b0;
    wait (hold_start === 1'b1);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  // Every accepted LED request is checked against the oldest prediction.
  always @(posedge clk) begin
    if (!rst && led_ch.valid && led_ch.ready) begin
      sb.check_led('{led_index:    led_ch.led_index,
                     red:          led_ch.red,
                     green:        led_ch.green,
                     stop_request: led_ch.stop_request,
                     frame_error:  led_ch.frame_error,
                     last:         led_ch.last});
    end
  end

  initial begin : stimulus
    logic [7:0] limits [PHASE_COUNT];
    logic [7:0] bad;
    int start_count;
    int pick;
    int s;
    sb            = new();
    pend_gap      = 0;
    no_idle       = 1'b0;
    hold_start    = 1'b0;
    offered_items = 0;
    shared_min    = 8'd40;
    rst           = 1'b1;
    rx_ch.valid   = 1'b0;
    rx_ch.rx_byte = 8'd0;
    cfg_we        = 1'b0;
    cfg_wdata     = 8'd0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed part, run with the threshold at its reset value. Bytes outside
    // a frame are ignored, including the extremes of the byte range.
    send_byte(8'd0, 1'b0);
    send_byte(8'd255, 1'b0);
    send_byte(8'd17, 1'b0);
    // A start byte as the sensor code is a bad frame; it does not restart one.
    send_byte(START_BYTE, 1'b1);
    send_byte(START_BYTE, 1'b1);
    // A code just past the last sensor is a bad frame as well.
    send_byte(START_BYTE, 1'b1);
    send_byte(8'(FIRST_CODE + SENSOR_COUNT), 1'b1);
    // A full sensor 0 frame, with a stored data byte equal to the start byte.
    send_byte(START_BYTE, 1'b1);
    send_byte(FIRST_CODE, 1'b1);
    foreach (DIRECTED_ECHO[k]) send_byte(DIRECTED_ECHO[k], 1'b1);

    // Each random phase runs under its own threshold, the extremes included.
    limits = '{8'd255, 8'd0, 8'($urandom), 8'd1, 8'($urandom_range(2, 254)), 8'd128};

    for (int p = 0; p < PHASE_COUNT; p++) begin
      stop_sending();
      wait_drained();
      // One phase runs with no idling on either side.
      no_idle = (p == 3);
      write_threshold(limits[p]);
      if (p == 1) hold_start = 1'b1;
      shared_min  = pick_min();
      start_count = offered_items;
      while (offered_items - start_count < PHASE_ITEMS) begin
        // A few ignored bytes between frames; they skip the start byte.
        repeat ($urandom_range(0, 2)) begin
          bad = 8'($urandom_range(0, 254));
          if (bad >= START_BYTE) bad++;
          send_byte(bad, 1'b0);
        end
        pick = $urandom_range(0, 99);
        s    = $urandom_range(0, SENSOR_COUNT - 1);
        if (pick < 12) begin
          // Broken header: anything but a sensor code after the start byte.
          if ($urandom_range(0, 3) == 0) begin
            bad = START_BYTE;
          end else begin
            bad = 8'($urandom_range(0, 252));
            if (bad >= FIRST_CODE) bad = 8'(bad + SENSOR_COUNT);
          end
          send_byte(START_BYTE, 1'b1);
          send_byte(bad, 1'b1);
        end else if (pick < 40) begin
          for (int k = 0; k < SENSOR_COUNT; k++) send_frame(k, FILL_ALIGNED);
        end else if (pick < 60) begin
          send_frame(s, FILL_ALIGNED);
        end else if (pick < 78) begin
          send_frame(s, FILL_BOUNDARY);
        end else if (pick < 93) begin
          send_frame(s, FILL_RANDOM);
        end else begin
          send_frame(s, FILL_ZERO);
        end
        if ($urandom_range(0, 9) == 0) shared_min = pick_min();
      end
    end

    stop_sending();
    wait_drained();
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("Simulation FAILED");
    $finish;
  end

endmodule

[sim.f]
src/ufpm_pkg.sv
src/ufpm_if.sv
src/ufpm_cmd_fifo.sv
src/ufpm_front.sv
src/ufpm_back.sv
src/ultrasonic_frame_proximity_monitor_top.sv
test/tb_ultrasonic_frame_proximity_monitor_top.sv
